### rtl/json_pretty_printer_assert.svh
// ----------------------------------------------------------------------------
// json_pretty_printer_assert.svh
// Assertion macros used by the pretty printer checker.
// ----------------------------------------------------------------------------
`ifndef JSON_PRETTY_PRINTER_ASSERT_SVH
`define JSON_PRETTY_PRINTER_ASSERT_SVH

// Implication checked outside of reset.
`define JPP_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jpp assertion failed");

// Next-cycle implication that also runs during reset.
`define JPP_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("jpp assertion failed");

`endif

### rtl/jpp_pkg.sv
// ----------------------------------------------------------------------------
// jpp_pkg
// Constants, character codes and sequencer states of the JSON pretty printer.
// ----------------------------------------------------------------------------
package jpp_pkg;

   localparam int MAX_DEPTH = 8;
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
   localparam int INDENT_W  = 3;
   localparam int PAD_W     = $clog2(MAX_DEPTH * ((1 << INDENT_W) - 1) + 1);
   localparam int PROD_W    = DEPTH_W + INDENT_W;

   localparam logic [INDENT_W-1:0] INDENT_RESET = INDENT_W'(2);

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAD,
      ST_SECOND,
      ST_PAD,
      ST_TAIL
   } jpp_state_type;

endpackage

### rtl/json_pretty_printer.sv
// ----------------------------------------------------------------------------
// json_pretty_printer
// Re-indents compact JSON text, one input byte in, a run of bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one byte of compact JSON per item; req_start_text clears the
//            depth and string flags before that byte is handled.
//   rsp_*  : formatted bytes, one per item; rsp_last_of_run marks the final
//            byte caused by an input, rsp_nesting_fault flags every byte of
//            an input whose depth change saturated.
//   csr_*  : indent width (spaces per level), write only, reset value 2.
// Timing:
//   An input makes 0 to 58 output bytes. It is decoded into the run plan
//   registers, then sent one byte per cycle while the receiver does not
//   stall, out of a single output register. The indent run is counted down
//   by one pad counter, so runs of spaces make braces and commas the
//   longest runs.
// Reset:
//   Synchronous, active high; clears the flags, depth, sequencer and output
//   valid, and sets the indent width to 2.
// Stall:
//   A stalled output byte holds; the sequencer waits and req_stall stays
//   high until the last byte of the run is in the output register.
// ----------------------------------------------------------------------------
module json_pretty_printer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_in_char,
   input  logic                         req_start_text,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_char,
   output logic                         rsp_last_of_run,
   output logic                         rsp_nesting_fault,
   input  logic                         csr_write_enable,
   input  logic [jpp_pkg::INDENT_W-1:0] csr_write_data
);
   import jpp_pkg::*;

   // state and configuration
   jpp_state_type        state_ff, state_in;
   logic [INDENT_W-1:0]  indent_width_ff;
   logic                 inside_string_ff, inside_string_in;
   logic                 escape_pending_ff, escape_pending_in;
   logic [DEPTH_W-1:0]   nest_depth_ff, nest_depth_in;

   // run plan for the current item
   logic                 lead_en_ff, lead_en_in;
   logic [7:0]           lead_char_ff, lead_char_in;
   logic                 second_en_ff, second_en_in;
   logic [7:0]           second_char_ff, second_char_in;
   logic [PAD_W-1:0]     pad_ff, pad_in;
   logic                 tail_en_ff, tail_en_in;
   logic [7:0]           tail_char_ff, tail_char_in;
   logic                 fault_ff, fault_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_fault_ff, rsp_fault_in;

   logic                 out_free;
   logic                 str_w, esc_w;
   logic [DEPTH_W-1:0]   dep_w;
   logic                 pad_use;
   logic [PROD_W-1:0]    pad_prod;
   logic                 pad_nz;

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_char      = rsp_char_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_nesting_fault = rsp_fault_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pad_nz   = (pad_ff != '0);

   // flags after an optional start of text
   assign str_w = req_start_text ? 1'b0 : inside_string_ff;
   assign esc_w = req_start_text ? 1'b0 : escape_pending_ff;
   assign dep_w = req_start_text ? '0 : nest_depth_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         indent_width_ff   <= INDENT_RESET;
         inside_string_ff  <= 1'b0;
         escape_pending_ff <= 1'b0;
         nest_depth_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         inside_string_ff  <= inside_string_in;
         escape_pending_ff <= escape_pending_in;
         nest_depth_ff     <= nest_depth_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (csr_write_enable) begin
            indent_width_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lead_en_ff     <= lead_en_in;
      lead_char_ff   <= lead_char_in;
      second_en_ff   <= second_en_in;
      second_char_ff <= second_char_in;
      pad_ff         <= pad_in;
      tail_en_ff     <= tail_en_in;
      tail_char_ff   <= tail_char_in;
      fault_ff       <= fault_in;
      rsp_char_ff    <= rsp_char_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_fault_ff   <= rsp_fault_in;
   end

   // decode and run sequencer
   always_comb begin
      state_in          = state_ff;
      inside_string_in  = inside_string_ff;
      escape_pending_in = escape_pending_ff;
      nest_depth_in     = nest_depth_ff;
      lead_en_in        = lead_en_ff;
      lead_char_in      = lead_char_ff;
      second_en_in      = second_en_ff;
      second_char_in    = second_char_ff;
      pad_in            = pad_ff;
      tail_en_in        = tail_en_ff;
      tail_char_in      = tail_char_ff;
      fault_in          = fault_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_char_in       = rsp_char_ff;
      rsp_last_in       = rsp_last_ff;
      rsp_fault_in      = rsp_fault_ff;
      pad_use           = 1'b0;
      pad_prod          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               inside_string_in  = str_w;
               escape_pending_in = esc_w;
               nest_depth_in     = dep_w;
               lead_en_in        = 1'b1;
               lead_char_in      = req_in_char;
               second_en_in      = 1'b0;
               second_char_in    = CH_LF;
               tail_en_in        = 1'b0;
               tail_char_in      = req_in_char;
               fault_in          = 1'b0;
               if (str_w) begin
                  // string body passes through
                  if (esc_w) begin
                     escape_pending_in = 1'b0;
                  end else if (req_in_char == CH_BSLASH) begin
                     escape_pending_in = 1'b1;
                  end else if (req_in_char == CH_QUOTE) begin
                     inside_string_in = 1'b0;
                  end
               end else begin
                  unique case (req_in_char)
                     CH_QUOTE: begin
                        inside_string_in = 1'b1;
                     end
                     CH_LBRACE, CH_LBRACK: begin
                        second_en_in = 1'b1;
                        pad_use      = 1'b1;
                        if (dep_w >= DEPTH_W'(MAX_DEPTH)) begin
                           nest_depth_in = DEPTH_W'(MAX_DEPTH);
                           fault_in      = 1'b1;
                        end else begin
                           nest_depth_in = dep_w + 1'b1;
                        end
                     end
                     CH_RBRACE, CH_RBRACK: begin
                        lead_char_in = CH_LF;
                        tail_en_in   = 1'b1;
                        pad_use      = 1'b1;
                        if (dep_w == '0) begin
                           fault_in = 1'b1;
                        end else begin
                           nest_depth_in = dep_w - 1'b1;
                        end
                     end
                     CH_COMMA: begin
                        second_en_in = 1'b1;
                        pad_use      = 1'b1;
                     end
                     CH_COLON: begin
                        second_en_in   = 1'b1;
                        second_char_in = CH_SPACE;
                     end
                     CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                        lead_en_in = 1'b0;
                     end
                     default: begin
                     end
                  endcase
               end
               // indent length at the new depth
               pad_prod = PROD_W'(nest_depth_in) * PROD_W'(indent_width_ff);
               pad_in   = pad_use ? pad_prod[PAD_W-1:0] : '0;
               state_in = lead_en_in ? ST_LEAD : ST_IDLE;
            end
         end
         ST_LEAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = lead_char_ff;
               rsp_fault_in = fault_ff;
               rsp_last_in  = !(second_en_ff || pad_nz || tail_en_ff);
               if (second_en_ff) begin
                  state_in = ST_SECOND;
               end else if (pad_nz) begin
                  state_in = ST_PAD;
               end else if (tail_en_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SECOND: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = second_char_ff;
               rsp_fault_in = fault_ff;
               rsp_last_in  = !(pad_nz || tail_en_ff);
               if (pad_nz) begin
                  state_in = ST_PAD;
               end else if (tail_en_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            // one space per cycle while the output is free, counted down
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_SPACE;
               rsp_fault_in = fault_ff;
               pad_in       = pad_ff - 1'b1;
               rsp_last_in  = (pad_ff == PAD_W'(1)) && !tail_en_ff;
               if (pad_ff == PAD_W'(1)) begin
                  state_in = tail_en_ff ? ST_TAIL : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = tail_char_ff;
               rsp_fault_in = fault_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/jpp_checker.sv
// ----------------------------------------------------------------------------
// jpp_checker
// Port-level assertions for the JSON pretty printer, bound to the top level.
// ----------------------------------------------------------------------------
`include "json_pretty_printer_assert.svh"

module jpp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [7:0]                   req_in_char,
   input logic                         req_start_text,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [7:0]                   rsp_out_char,
   input logic                         rsp_last_of_run,
   input logic                         rsp_nesting_fault,
   input logic                         csr_write_enable,
   input logic [jpp_pkg::INDENT_W-1:0] csr_write_data
);
   import jpp_pkg::*;

   // a stalled output item holds
   `JPP_ASSERT_IMPLIES(a_rsp_hold, clock, reset, $past(rsp_valid && rsp_stall && !reset), rsp_valid && $stable(rsp_out_char) && $stable(rsp_last_of_run))

   // faults only come from structural runs
   `JPP_ASSERT_IMPLIES(a_fault_chars, clock, reset, rsp_valid && rsp_nesting_fault, rsp_out_char == CH_LF || rsp_out_char == CH_SPACE || rsp_out_char == CH_LBRACE || rsp_out_char == CH_LBRACK || rsp_out_char == CH_RBRACE || rsp_out_char == CH_RBRACK)

   // reset leaves the block empty and ready
   `JPP_ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid && !req_stall)

endmodule

bind json_pretty_printer jpp_checker u_jpp_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the JSON pretty printer.
// ----------------------------------------------------------------------------
// A queue of compact JSON bytes feeds a clocked driver; a clocked monitor
// keeps its own formatter state (string flag, escape flag, depth, indent)
// and expands each accepted byte into the formatted bytes it must produce.
// Every output byte is checked field by field against the oldest one due.
// Stimulus: a directed pass over saturation, whitespace, escapes and the
// longest runs, then random JSON texts mixed with raw noise under three
// indent settings and three idling mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
   import jpp_pkg::*;

   localparam int PHASE_BYTES = 60;   // counted input items per random phase
   localparam int HOLD_AT     = 60;   // accepted items before the long hold
   localparam int HOLD_LEN    = 300;  // cycles of the long hold-off
   localparam int GAP_CYCLES  = 4;    // settle before a register write
   localparam int TAIL_CYCLES = 64;   // settle at the end of the run

   typedef struct packed {
      logic [7:0] in_char;
      logic       start_text;
   } text_byte_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_run;
      logic       nesting_fault;
   } fmt_byte_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_in_char = 8'h00;
   logic                req_start_text = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_out_char;
   logic                rsp_last_of_run;
   logic                rsp_nesting_fault;
   logic                csr_write_enable = 1'b0;
   logic [INDENT_W-1:0] csr_write_data = '0;

   text_byte_type json_in_bytes[$];
   fmt_byte_type  formatted_bytes_due[$];
   fmt_byte_type  due_byte;

   // formatter state as seen by the bench
   logic                fmt_in_string;
   logic                fmt_escape;
   logic [DEPTH_W-1:0]  fmt_depth;
   logic [INDENT_W-1:0] fmt_indent;

   logic req_taken = 1'b0;
   int   items_accepted = 0;
   int   bytes_queued = 0;
   int   mismatch_count = 0;
   int   send_idle_pct = 16;
   int   recv_idle_pct = 73;
   int   hold_left = 0;
   logic hold_done = 1'b0;

   json_pretty_printer i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_char       (req_in_char),
      .req_start_text    (req_start_text),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_char      (rsp_out_char),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_nesting_fault (rsp_nesting_fault),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expand one accepted byte into the formatted bytes it must produce.
   task automatic format_json_byte(input logic [7:0] ch, input logic start);
      logic [7:0]   run_bytes[$];
      logic         fault;
      int           pad;
      fmt_byte_type entry;
      fault = 1'b0;
      pad = 0;
      if (start) begin
         fmt_in_string = 1'b0;
         fmt_escape = 1'b0;
         fmt_depth = '0;
      end
      if (fmt_in_string) begin
         run_bytes.push_back(ch);
         if (fmt_escape)
            fmt_escape = 1'b0;
         else if (ch == CH_BSLASH)
            fmt_escape = 1'b1;
         else if (ch == CH_QUOTE)
            fmt_in_string = 1'b0;
      end else begin
         case (ch)
            CH_QUOTE: begin
               run_bytes.push_back(ch);
               fmt_in_string = 1'b1;
            end
            CH_LBRACE, CH_LBRACK: begin
               run_bytes.push_back(ch);
               run_bytes.push_back(CH_LF);
               // opening at full depth keeps the depth and flags it
               if (fmt_depth >= MAX_DEPTH)
                  fault = 1'b1;
               else
                  fmt_depth = fmt_depth + 1'b1;
               pad = int'(fmt_depth) * int'(fmt_indent);
               repeat (pad) run_bytes.push_back(CH_SPACE);
            end
            CH_RBRACE, CH_RBRACK: begin
               run_bytes.push_back(CH_LF);
               // closing at depth zero keeps zero and flags it
               if (fmt_depth == 0)
                  fault = 1'b1;
               else
                  fmt_depth = fmt_depth - 1'b1;
               pad = int'(fmt_depth) * int'(fmt_indent);
               repeat (pad) run_bytes.push_back(CH_SPACE);
               run_bytes.push_back(ch);
            end
            CH_COMMA: begin
               run_bytes.push_back(ch);
               run_bytes.push_back(CH_LF);
               pad = int'(fmt_depth) * int'(fmt_indent);
               repeat (pad) run_bytes.push_back(CH_SPACE);
            end
            CH_COLON: begin
               run_bytes.push_back(ch);
               run_bytes.push_back(CH_SPACE);
            end
            CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
            default: run_bytes.push_back(ch);
         endcase
      end
      foreach (run_bytes[k]) begin
         entry.out_char = run_bytes[k];
         entry.last_of_run = (k == run_bytes.size() - 1);
         entry.nesting_fault = fault;
         formatted_bytes_due.push_back(entry);
      end
   endtask

   // Prediction and checking, both on the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         fmt_in_string = 1'b0;
         fmt_escape = 1'b0;
         fmt_depth = '0;
         fmt_indent = INDENT_RESET;
         req_taken <= 1'b0;
         items_accepted <= 0;
      end else begin
         if (csr_write_enable)
            fmt_indent = csr_write_data;
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            format_json_byte(req_in_char, req_start_text);
            items_accepted <= items_accepted + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (formatted_bytes_due.size() == 0) begin
               $error("out_char: expected nothing, actual %h", rsp_out_char);
               mismatch_count++;
            end else begin
               due_byte = formatted_bytes_due.pop_front();
               if (rsp_out_char !== due_byte.out_char) begin
                  $error("out_char: expected %h, actual %h",
                         due_byte.out_char, rsp_out_char);
                  mismatch_count++;
               end
               if (rsp_last_of_run !== due_byte.last_of_run) begin
                  $error("last_of_run: expected %b, actual %b",
                         due_byte.last_of_run, rsp_last_of_run);
                  mismatch_count++;
               end
               if (rsp_nesting_fault !== due_byte.nesting_fault) begin
                  $error("nesting_fault: expected %b, actual %b",
                         due_byte.nesting_fault, rsp_nesting_fault);
                  mismatch_count++;
               end
            end
         end
      end
   end

   // Input driver: offers the next queued item once the current one is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (json_in_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_in_char <= json_in_bytes[0].in_char;
            req_start_text <= json_in_bytes[0].start_text;
            void'(json_in_bytes.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Output receiver: random stalls plus one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && items_accepted >= HOLD_AT) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic push_json_byte(input logic [7:0] ch, input logic start);
      text_byte_type item;
      item.in_char = ch;
      item.start_text = start;
      json_in_bytes.push_back(item);
      // bare whitespace is mostly dropped, so it does not count
      if (!(ch inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}))
         bytes_queued++;
   endtask

   task automatic write_indent(input logic [INDENT_W-1:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // Wait until every item is taken and every formatted byte has come out.
   task automatic wait_idle();
      do
         @(posedge clock);
      while (json_in_bytes.size() != 0 || (req_valid && req_stall));
      @(negedge clock);
      while (formatted_bytes_due.size() != 0)
         @(negedge clock);
      repeat (GAP_CYCLES) @(negedge clock);
   endtask

   // One JSON-like text: balanced nesting, strings with escapes, literals.
   task automatic add_json_text(input int target);
      string str_chars;
      string esc_chars;
      string lit_chars;
      int    open_levels;
      int    first_count;
      int    pick;
      str_chars = "abcXYZ019 {}[],:\t";
      esc_chars = "\"\\nt/u";
      lit_chars = "0123456789-.eEtrufalsn";
      first_count = bytes_queued;
      push_json_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACK, 1'b1);
      open_levels = 1;
      while (bytes_queued - first_count < target || open_levels > 0) begin
         pick = $urandom_range(99);
         if (open_levels > 0 && (bytes_queued - first_count >= target || pick < 15)) begin
            push_json_byte($urandom_range(1) ? CH_RBRACE : CH_RBRACK, 1'b0);
            open_levels--;
         end else if (pick < 35 && open_levels < MAX_DEPTH + 2) begin
            // may go up to two past full depth to hit saturation
            push_json_byte($urandom_range(1) ? CH_LBRACE : CH_LBRACK, 1'b0);
            open_levels++;
         end else if (pick < 60) begin
            push_json_byte(CH_QUOTE, 1'b0);
            repeat ($urandom_range(6)) begin
               if ($urandom_range(4) == 0) begin
                  push_json_byte(CH_BSLASH, 1'b0);
                  push_json_byte(esc_chars[$urandom_range(esc_chars.len() - 1)], 1'b0);
               end else begin
                  push_json_byte(str_chars[$urandom_range(str_chars.len() - 1)], 1'b0);
               end
            end
            push_json_byte(CH_QUOTE, 1'b0);
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 4))
               push_json_byte(lit_chars[$urandom_range(lit_chars.len() - 1)], 1'b0);
         end else if (pick < 88) begin
            push_json_byte(CH_COMMA, 1'b0);
         end else if (pick < 95) begin
            push_json_byte(CH_COLON, 1'b0);
         end else begin
            case ($urandom_range(3))
               0: push_json_byte(CH_SPACE, 1'b0);
               1: push_json_byte(CH_TAB, 1'b0);
               2: push_json_byte(CH_LF, 1'b0);
               default: push_json_byte(CH_CR, 1'b0);
            endcase
         end
      end
   endtask

   // Main sequence
   initial begin
      logic [INDENT_W-1:0] phase_indent[3];
      int                  phase_goal;
      phase_indent = '{3'd0, 3'd5, 3'd3};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed items at the widest indent
      write_indent(3'd7);
      push_json_byte(CH_RBRACE, 1'b1);          // close at depth zero
      push_json_byte(CH_LBRACE, 1'b1);
      repeat (MAX_DEPTH) push_json_byte(CH_LBRACK, 1'b0); // last one saturates
      push_json_byte(CH_COMMA, 1'b0);           // longest run
      push_json_byte(CH_COLON, 1'b0);
      push_json_byte(CH_RBRACK, 1'b0);
      push_json_byte(CH_SPACE, 1'b0);
      push_json_byte(CH_TAB, 1'b0);
      push_json_byte(CH_LF, 1'b0);
      push_json_byte(CH_CR, 1'b0);
      push_json_byte(8'hFF, 1'b0);
      push_json_byte(8'h00, 1'b0);
      // string holding a structural char and an escaped quote
      push_json_byte(CH_QUOTE, 1'b0);
      push_json_byte(CH_LBRACE, 1'b0);
      push_json_byte(CH_BSLASH, 1'b0);
      push_json_byte(CH_QUOTE, 1'b0);
      push_json_byte("a", 1'b0);
      push_json_byte(CH_QUOTE, 1'b0);
      // start of text clears an open string and the depth
      push_json_byte(CH_QUOTE, 1'b0);
      push_json_byte(CH_RBRACE, 1'b1);
      wait_idle();

      // random phases: sender-light, receiver-light, then no idling
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 16 : 0;
         write_indent(phase_indent[phase]);
         phase_goal = bytes_queued + PHASE_BYTES;
         while (bytes_queued < phase_goal) begin
            if ($urandom_range(9) < 8) begin
               add_json_text($urandom_range(4, 18));
            end else begin
               // raw noise bytes with random restarts
               repeat ($urandom_range(1, 6))
                  push_json_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            end
         end
         wait_idle();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/jpp_pkg.sv
rtl/json_pretty_printer.sv
rtl/jpp_checker.sv
tb/sv/testbench.sv
